// ===== rtl/core/trba_pkg.sv =====
package trba_pkg;

  // Defaults for the map geometry.
  localparam int unsigned MAP_BITS_DEF  = 4096;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Fixed field widths.
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned OFF_W     = 12;
  localparam int unsigned POS_W     = 14;
  localparam int unsigned CFG_IDX_W = 2;

  // An allocate never grants an offset that does not fit the result field.
  localparam logic [CNT_W-1:0] OFFSET_LIMIT = 13'd4096;

  localparam logic [CNT_W-1:0] RST_INODE_COUNT     = 13'd256;
  localparam logic [CNT_W-1:0] RST_DATA_COUNT      = 13'd3840;
  localparam logic [OFF_W-1:0] RST_PROTECTED_INODE = 12'd0;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REGION_INODE = 1'b0;
  localparam logic REGION_DATA  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_INODE_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECTED_INODE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_e;

  typedef struct packed {
    logic             command;
    logic             region;
    logic [OFF_W-1:0] entry_offset;
  } alloc_req_t;

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] granted_offset;
  } alloc_rsp_t;

endpackage

// ===== rtl/core/two_region_bitmap_allocator.sv =====
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+--------------------------------
// command   | in        | start, busy                | cmd_i (alloc_req_t)
// result    | out       | result_valid_o (strobe)    | result_o (alloc_rsp_t)
// config    | in        | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// After reset the map is cleared one word per cycle, all MAP_WORDS words, with busy high.
// A free keeps busy high while a reciprocal multiply splits the bit position into word
// and bit index, then for one map read and one write. An allocate keeps busy high for the
// same split and then for the scan of the map words (at most MAP_WORDS); the single map
// read port examines one word per cycle. A request that is rejected at once (out of range,
// protected, empty region) is answered in the next cycle and never raises busy.
// Each result shows for one cycle, in the cycle busy drops; it cannot be held off.
module two_region_bitmap_allocator
  import trba_pkg::*;
#(
  parameter int unsigned MAP_BITS  = MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  alloc_req_t           cmd_i,
  output logic                 result_valid_o,
  output alloc_rsp_t           result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW        = $clog2(WORD_BITS);
  localparam int unsigned LIM_W     = $clog2(MAP_BITS + 1);
  localparam int unsigned CMP_W     = (LIM_W > POS_W) ? LIM_W : POS_W;
  localparam int unsigned RCP_SH    = POS_W + BW;
  localparam int unsigned RCP_W     = POS_W + 2;
  localparam int unsigned PROD_W    = POS_W + RCP_W;

  localparam logic [CMP_W-1:0] MAP_LIMIT = CMP_W'(MAP_BITS);
  localparam logic [CMP_W-1:0] WORD_STEP = CMP_W'(WORD_BITS);
  localparam logic [AW-1:0]    WORD_LAST = AW'(MAP_WORDS - 1);
  // Rounded-up reciprocal of the word size; the quotient is exact for every position
  // below 2^POS_W.
  localparam logic [RCP_W-1:0] RECIP     =
    RCP_W'(((1 << RCP_SH) + WORD_BITS - 1) / WORD_BITS);
  localparam logic [POS_W-1:0] WORD_MUL  = POS_W'(WORD_BITS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FCHK  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    word_q, word_d;
  logic             rsp_valid_q, rsp_valid_d;
  alloc_rsp_t       rsp_q, rsp_d;
  logic [CNT_W-1:0] inode_count_q, data_count_q;
  logic [OFF_W-1:0] protected_q;

  logic             cmd_free_q, cmd_free_d;
  logic [POS_W-1:0] num_q, num_d;
  logic [POS_W-1:0] quot_q, quot_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic [CMP_W-1:0] span_q, span_d;
  logic [CMP_W-1:0] rem_cnt_q, rem_cnt_d;
  logic [OFF_W-1:0] koff_q, koff_d;
  logic             first_q, first_d;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Request decode.
  logic [POS_W-1:0] start_pos, free_pos, alloc_sum;
  logic [CNT_W-1:0] region_size, alloc_lim;
  logic [CMP_W-1:0] alloc_end;
  logic             alloc_empty, free_bad;

  // Scan of the word that is in rd_data_q.
  logic [BW-1:0]        scan_lo;
  logic [WORD_BITS-1:0] free_bits, sel_bit;
  logic                 found;
  logic [BW-1:0]        found_idx;

  // Split of a bit position into word and bit index.
  logic [PROD_W-1:0] div_prod;
  logic [POS_W-1:0]  div_back;
  logic [BW-1:0]     div_rem;

  assign cfg_ready_o    = 1'b1;
  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rsp_valid_q;
  assign result_o       = rsp_q;

  always_comb begin
    start_pos   = (cmd_i.region == REGION_DATA) ? POS_W'(inode_count_q) : '0;
    region_size = (cmd_i.region == REGION_DATA) ? data_count_q : inode_count_q;
    alloc_lim   = (region_size > OFFSET_LIMIT) ? OFFSET_LIMIT : region_size;
    alloc_sum   = start_pos + POS_W'(alloc_lim);
    alloc_end   = (CMP_W'(alloc_sum) < MAP_LIMIT) ? CMP_W'(alloc_sum) : MAP_LIMIT;
    alloc_empty = (CMP_W'(start_pos) >= alloc_end);
    free_pos    = start_pos + POS_W'(cmd_i.entry_offset);
    free_bad    = (CNT_W'(cmd_i.entry_offset) >= region_size) ||
                  (CMP_W'(free_pos) >= MAP_LIMIT) ||
                  ((cmd_i.region == REGION_INODE) && (cmd_i.entry_offset == protected_q));
  end

  always_comb begin
    div_prod = PROD_W'(num_q) * PROD_W'(RECIP);
    div_back = quot_q * WORD_MUL;
    div_rem  = BW'(num_q - div_back);
  end

  // Only bits from the start position on (first word) and below the end of the
  // region are candidates.
  always_comb begin
    scan_lo = first_q ? bit_q : '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      free_bits[i] = !rd_data_q[i] && (BW'(i) >= scan_lo) && (CMP_W'(i) < rem_cnt_q);
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        found     = 1'b1;
        found_idx = BW'(i);
      end
    end
  end

  assign sel_bit = WORD_BITS'(1) << found_idx;

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    cmd_free_d  = cmd_free_q;
    num_d       = num_q;
    quot_d      = quot_q;
    bit_d       = bit_q;
    span_d      = span_q;
    rem_cnt_d   = rem_cnt_q;
    koff_d      = koff_q;
    first_d     = first_q;
    rd_en       = 1'b0;
    rd_addr     = word_q;
    wr_en       = 1'b0;
    wr_addr     = word_q;
    wr_data     = '0;

    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (word_q == WORD_LAST) begin
          word_d  = '0;
          state_d = S_IDLE;
        end else begin
          word_d = word_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_free_d = (cmd_i.command == CMD_FREE);
          if (cmd_i.command == CMD_ALLOC) begin
            num_d  = start_pos;
            span_d = alloc_end - CMP_W'(start_pos);
          end else begin
            num_d = free_pos;
          end
          if ((cmd_i.command == CMD_ALLOC) ? alloc_empty : free_bad) begin
            rsp_valid_d          = 1'b1;
            rsp_d.status         = (cmd_i.command == CMD_ALLOC) ? ST_FULL : ST_RANGE;
            rsp_d.granted_offset = '0;
          end else begin
            state_d = S_DIV;
          end
        end
      end

      S_DIV: begin
        quot_d  = POS_W'(div_prod[PROD_W-1:RCP_SH]);
        state_d = S_READ;
      end

      S_READ: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(quot_q);
        word_d    = AW'(quot_q);
        bit_d     = div_rem;
        rem_cnt_d = span_q + CMP_W'(div_rem);
        // Offset of the word's bit 0 relative to the region start, modulo 2^12.
        koff_d    = OFF_W'(0) - OFF_W'(div_rem);
        first_d   = 1'b1;
        state_d   = cmd_free_q ? S_FCHK : S_SCAN;
      end

      S_SCAN: begin
        // Fetch the next word ahead so that one word is examined per cycle.
        if (word_q != WORD_LAST) begin
          rd_en   = 1'b1;
          rd_addr = word_q + 1'b1;
        end
        if (found) begin
          wr_en                = 1'b1;
          wr_data              = rd_data_q | sel_bit;
          rsp_valid_d          = 1'b1;
          rsp_d.status         = ST_OK;
          rsp_d.granted_offset = koff_q + OFF_W'(found_idx);
          state_d              = S_IDLE;
        end else if (rem_cnt_q <= WORD_STEP) begin
          rsp_valid_d          = 1'b1;
          rsp_d.status         = ST_FULL;
          rsp_d.granted_offset = '0;
          state_d              = S_IDLE;
        end else begin
          rem_cnt_d = rem_cnt_q - WORD_STEP;
          koff_d    = koff_q + OFF_W'(WORD_BITS);
          word_d    = word_q + 1'b1;
          first_d   = 1'b0;
        end
      end

      S_FCHK: begin
        rsp_valid_d          = 1'b1;
        rsp_d.granted_offset = '0;
        state_d              = S_IDLE;
        if (rd_data_q[bit_q]) begin
          wr_en        = 1'b1;
          wr_data      = rd_data_q & ~(WORD_BITS'(1) << bit_q);
          rsp_d.status = ST_OK;
        end else begin
          rsp_d.status = ST_FREE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      word_q        <= '0;
      rsp_valid_q   <= 1'b0;
      inode_count_q <= RST_INODE_COUNT;
      data_count_q  <= RST_DATA_COUNT;
      protected_q   <= RST_PROTECTED_INODE;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_INODE_COUNT:     inode_count_q <= cfg_data_i;
          CFG_DATA_COUNT:      data_count_q  <= cfg_data_i;
          CFG_PROTECTED_INODE: protected_q   <= cfg_data_i[OFF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q      <= rsp_d;
    cmd_free_q <= cmd_free_d;
    num_q      <= num_d;
    quot_q     <= quot_d;
    bit_q      <= bit_d;
    span_q     <= span_d;
    rem_cnt_q  <= rem_cnt_d;
    koff_q     <= koff_d;
    first_q    <= first_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= map_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/trba_checker.sv =====
module trba_checker
  import trba_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input alloc_rsp_t result_o
);

  // A result answers an item accepted in the cycle before or ends a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result without an accepted item");

  // A result is never shown while the block is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // A strobed result carries known values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown(result_o))
    else $error("result carries unknown bits");

  // Only a successful request (status OK) may carry a nonzero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status != ST_OK)) |-> (result_o.granted_offset == '0))
    else $error("nonzero offset on a failed request");

endmodule

bind two_region_bitmap_allocator trba_checker u_trba_checker (.*);
